// File: hw/rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants, result codes and handshake structs of the command
// segmenter.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int CMD_BYTES_DEF   = 64;
  localparam int MAX_FRAMES      = 10;

  localparam int PAYLOAD_MAX  = 7;
  localparam int FRAME_BYTES  = 8;
  localparam int HEADER_BYTES = 2;

  localparam int FN_W   = 4;  // frame number
  localparam int CALC_W = 8;  // length and offset arithmetic
  localparam int CNTB_W = 4;  // byte counts inside one frame

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic              start;
    logic [FN_W-1:0]   fn;
    logic [CALC_W-1:0] len;
  } gather_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } gather_resp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    logic        last;
  } out_item_t;

endpackage

// File: hw/rtl/ccs_ram.sv
// ----------------------------------------------------------------------------
// ccs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ccs_gather.sv
// ----------------------------------------------------------------------------
// ccs_gather
// Frame gather sequencer: reads the address byte, the function code and the
// payload bytes of one frame from the command store, one byte per cycle.
// ----------------------------------------------------------------------------
module ccs_gather import ccs_pkg::*; #(
  parameter int SLOT_W = 4,
  parameter int OFF_W  = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gather_req_t             req_i,
  input  logic [SLOT_W-1:0]       slot_i,
  input  logic [7:0]              rdata_i,
  output logic [SLOT_W+OFF_W-1:0] raddr_o,
  output gather_resp_t            resp_o
);

  logic [CNTB_W-1:0] issue_q, total_q, rk_q, plen_q, plen_s;
  logic              rv_q, done_q, issue;
  logic [CALC_W-1:0] off_q, off_s, base_s, rem_s, rd_off;
  logic [SLOT_W-1:0] slot_q;
  logic [FN_W-1:0]   fn_q;
  logic [7:0]        idhi_q;
  logic [63:0]       data_q;
  logic [2:0]        dix;

  // payload of this frame: bytes left past the offset, capped at seven
  always_comb begin
    off_s  = (CALC_W'(req_i.fn) << 3) - CALC_W'(req_i.fn);
    base_s = off_s + CALC_W'(HEADER_BYTES);
    rem_s  = (req_i.len > base_s) ? req_i.len - base_s : '0;
    plen_s = (rem_s < CALC_W'(FRAME_BYTES)) ? rem_s[CNTB_W-1:0] : CNTB_W'(PAYLOAD_MAX);
  end

  assign issue   = (issue_q != total_q);
  // read k: header byte k for k < 2, else payload byte at offset + k
  assign rd_off  = (issue_q < CNTB_W'(HEADER_BYTES)) ? CALC_W'(issue_q)
                                                     : off_q + CALC_W'(issue_q);
  assign raddr_o = {slot_q, rd_off[OFF_W-1:0]};
  assign dix     = 3'(rk_q - CNTB_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= '0;
      total_q <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else if (req_i.start) begin
      issue_q <= '0;
      total_q <= plen_s + CNTB_W'(HEADER_BYTES);
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (issue) begin
        issue_q <= issue_q + CNTB_W'(1);
      end
      rv_q   <= issue;
      done_q <= rv_q && (rk_q == total_q - CNTB_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= issue_q;
    if (req_i.start) begin
      off_q  <= off_s;
      slot_q <= slot_i;
      fn_q   <= req_i.fn;
      plen_q <= plen_s;
      data_q <= '0;
    end else if (rv_q) begin
      if (rk_q == '0) begin
        idhi_q <= rdata_i;
      end else begin
        data_q[8*dix +: 8] <= rdata_i;
      end
    end
  end

  assign resp_o.done = done_q;
  assign resp_o.id   = {idhi_q, 4'b0000, fn_q};
  assign resp_o.len  = plen_q + 4'd1;
  assign resp_o.data = data_q;

endmodule

// File: hw/rtl/ccs_out_reg.sv
// ----------------------------------------------------------------------------
// ccs_out_reg
// Output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module ccs_out_reg import ccs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  input  logic      stall_i,
  output logic      free_o,
  output logic      valid_o,
  output out_item_t item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/can_command_segmenter_unit.sv
// ----------------------------------------------------------------------------
// can_command_segmenter_unit
// Stores incoming commands in a ring and cuts them into bus frames.
// ----------------------------------------------------------------------------
// Command bytes are written straight into a free slot of the command store
// (QUEUE_DEPTH+1 slots, so the slot being filled never collides with a stored
// command); a command byte that causes no result leaves the unit idle and the
// next request is taken in the following cycle. A final byte answers accepted
// or rejected through the output register. A frame is gathered from the store
// through its single read port, one byte per cycle, and then loaded into the
// output register; this follows a transmit-done request that moves on to
// another frame, and an accept that starts sending, after its answer.
// Requests are taken only between these sequences; a result waiting in the
// output register does not hold off the next request.
module can_command_segmenter_unit import ccs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int CMD_BYTES   = CMD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  cmd_byte_i,
  input  logic        cmd_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [15:0] frame_id_o,
  output logic [3:0]  frame_len_o,
  output logic [63:0] frame_data_o,
  output logic        out_last_o
);

  localparam int NSLOT     = QUEUE_DEPTH + 1;
  localparam int SLOT_W    = $clog2(NSLOT);
  localparam int OFF_W     = $clog2(CMD_BYTES);
  localparam int LEN_W     = $clog2(CMD_BYTES + 1);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = SLOT_W + OFF_W;
  localparam int MEM_DEPTH = NSLOT * (2 ** OFF_W);
  localparam int SUM_W     = SLOT_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACK    = 3'd1;
  localparam logic [2:0] S_GSTART = 3'd2;
  localparam logic [2:0] S_GWAIT  = 3'd3;
  localparam logic [2:0] S_FRAME  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d, head_inc, tail_inc;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              busy_q, busy_d;
  logic [FN_W-1:0]   fn_q, fn_d;
  logic [LEN_W-1:0]  inc_len_q, inc_len_d, new_len;
  logic              ovf_q, ovf_d, new_ovf;
  logic [1:0]        res_kind_q, res_kind_d;
  logic              res_last_q, res_last_d;
  logic              send_q, send_d;
  logic [LEN_W-1:0]  lens_q [NSLOT];
  logic              lens_we;

  logic              in_acc, can_write, reject, short_cmd, has_next;
  logic [CALC_W-1:0] head_len, next_fn, next_off;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_rdata;

  gather_req_t       greq;
  gather_resp_t      gresp;

  logic              out_load, out_free;
  out_item_t         out_item, out_cur;

  logic [SUM_W-1:0]  ring_sum, ring_pos;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign head_inc = (head_q == SLOT_W'(NSLOT - 1)) ? '0 : head_q + SLOT_W'(1);
  assign tail_inc = (tail_q == SLOT_W'(NSLOT - 1)) ? '0 : tail_q + SLOT_W'(1);

  // next frame exists if below the frame cap and payload remains past it
  assign head_len = CALC_W'(lens_q[head_q]);
  assign next_fn  = CALC_W'(fn_q) + CALC_W'(1);
  assign next_off = (next_fn << 3) - next_fn;
  assign has_next = (next_fn < CALC_W'(MAX_FRAMES)) &&
                    (head_len > next_off + CALC_W'(HEADER_BYTES));

  assign can_write = (inc_len_q < LEN_W'(CMD_BYTES));
  assign new_len   = can_write ? inc_len_q + LEN_W'(1) : inc_len_q;
  assign new_ovf   = ovf_q || !can_write;
  assign reject    = new_ovf || (count_q == CNT_W'(QUEUE_DEPTH));
  assign short_cmd = (new_len <= LEN_W'(HEADER_BYTES));
  assign mem_waddr = {tail_q, inc_len_q[OFF_W-1:0]};

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    busy_d     = busy_q;
    fn_d       = fn_q;
    inc_len_d  = inc_len_q;
    ovf_d      = ovf_q;
    res_kind_d = res_kind_q;
    res_last_d = res_last_q;
    send_d     = send_q;
    mem_we     = 1'b0;
    lens_we    = 1'b0;
    greq.start = 1'b0;
    greq.fn    = fn_q;
    greq.len   = head_len;
    out_load   = 1'b0;
    out_item   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (func_i) begin
            if (busy_q) begin
              if (has_next) begin
                fn_d    = fn_q + FN_W'(1);
                state_d = S_GSTART;
              end else begin
                // retire the head command, move on to the next one
                head_d = head_inc;
                fn_d   = '0;
                if (count_q != '0) begin
                  count_d = count_q - CNT_W'(1);
                end
                if (count_q > CNT_W'(1)) begin
                  state_d = S_GSTART;
                end else begin
                  busy_d = 1'b0;
                end
              end
            end
          end else begin
            mem_we    = can_write;
            inc_len_d = new_len;
            ovf_d     = new_ovf;
            if (cmd_last_i) begin
              inc_len_d  = '0;
              ovf_d      = 1'b0;
              state_d    = S_ACK;
              res_last_d = 1'b1;
              send_d     = 1'b0;
              if (reject) begin
                res_kind_d = KIND_REJECT;
              end else begin
                res_kind_d = KIND_ACCEPT;
                if (!short_cmd) begin
                  lens_we = 1'b1;
                  tail_d  = tail_inc;
                  count_d = count_q + CNT_W'(1);
                  if (!busy_q) begin
                    res_last_d = 1'b0;
                    send_d     = 1'b1;
                    busy_d     = 1'b1;
                    fn_d       = '0;
                  end
                end
              end
            end
          end
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_item.kind = res_kind_q;
          out_item.last = res_last_q;
          state_d       = send_q ? S_GSTART : S_IDLE;
        end
      end
      S_GSTART: begin
        greq.start = 1'b1;
        state_d    = S_GWAIT;
      end
      S_GWAIT: begin
        if (gresp.done) begin
          state_d = S_FRAME;
        end
      end
      S_FRAME: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_item.kind = KIND_FRAME;
          out_item.id   = gresp.id;
          out_item.len  = gresp.len;
          out_item.data = gresp.data;
          out_item.last = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      busy_q    <= 1'b0;
      fn_q      <= '0;
      inc_len_q <= '0;
      ovf_q     <= 1'b0;
      send_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      busy_q    <= busy_d;
      fn_q      <= fn_d;
      inc_len_q <= inc_len_d;
      ovf_q     <= ovf_d;
      send_q    <= send_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q <= res_kind_d;
    res_last_q <= res_last_d;
    if (lens_we) begin
      lens_q[tail_q] <= new_len;
    end
  end

  ccs_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (cmd_byte_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ccs_gather #(
    .SLOT_W (SLOT_W),
    .OFF_W  (OFF_W)
  ) u_gather (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (greq),
    .slot_i  (head_q),
    .rdata_i (mem_rdata),
    .raddr_o (mem_raddr),
    .resp_o  (gresp)
  );

  ccs_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .item_i  (out_item),
    .stall_i (out_stall_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .item_o  (out_cur)
  );

  assign out_kind_o   = out_cur.kind;
  assign frame_id_o   = out_cur.id;
  assign frame_len_o  = out_cur.len;
  assign frame_data_o = out_cur.data;
  assign out_last_o   = out_cur.last;

  assign ring_sum = SUM_W'(head_q) + SUM_W'(count_q);
  assign ring_pos = (ring_sum >= SUM_W'(NSLOT)) ? ring_sum - SUM_W'(NSLOT) : ring_sum;

  a_busy_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (count_q != '0))
    else $error("sender busy flag disagrees with stored command count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("stored command count above ring depth");

  a_ring_pointers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(tail_q) == ring_pos)
    else $error("tail slot does not match head slot plus count");

  a_gather_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gresp.done |-> state_q == S_GWAIT)
    else $error("frame gather finished outside of its wait state");

  a_gather_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    greq.start |=> state_q == S_GWAIT && !gresp.done)
    else $error("frame gather start not followed by wait");

endmodule
